### hdl/vpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpe_pkg
// Widths, limits and divider handshake types for the vblank period estimator.
// ----------------------------------------------------------------------------
package vpe_pkg;

    localparam int COUNT_W  = 32;
    localparam int TIME_W   = 64;
    localparam int PERIOD_W = 40;

    localparam int DIVIDEND_W = TIME_W;
    localparam int DIVISOR_W  = PERIOD_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

### hdl/vblank_period_estimator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vblank_period_estimator_core
// Running-mean frame period tracker fed by vblank events.
// ----------------------------------------------------------------------------
// One event is taken at a time. The first event, and any event whose counter
// has not advanced, goes straight to its result beat without a division. An
// accepted event runs up to three 64-step divisions (frame count, period,
// mean update), or two while the mean is still zero, one after another
// through a single bit-serial divider.
// A new event is taken as soon as the previous one is finished, even while
// its result beat still waits; the new event then holds in its last cycle
// until that beat has been taken.
// ----------------------------------------------------------------------------
module vblank_period_estimator_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // vbl_count[31:0], timestamp_ns[95:32]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // frames_elapsed[31:0], period_ns[71:32],
                                         // mean_period_ns[111:72]
    output logic         m_axis_tuser    // accepted[0]
);
    import vpe_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FR_GO,
        ST_FR_WAIT,
        ST_FR_FIX,
        ST_PER_GO,
        ST_PER_WAIT,
        ST_DELTA,
        ST_ABS,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_FINISH
    } state_t;

    state_t                state_reg,     state_next;
    logic                  armed_reg,     armed_next;
    logic [COUNT_W-1:0]    prev_cnt_reg,  prev_cnt_next;
    logic [TIME_W-1:0]     prev_time_reg, prev_time_next;
    logic [COUNT_W-1:0]    total_reg,     total_next;
    logic [PERIOD_W-1:0]   mean_reg,      mean_next;
    logic [PERIOD_W-1:0]   period_reg,    period_next;
    logic [TIME_W-1:0]     dt_reg,        dt_next;
    logic [COUNT_W-1:0]    frames_reg,    frames_next;
    logic                  acc_reg,       acc_next;
    logic                  rnd_reg,       rnd_next;
    logic [PERIOD_W:0]     delta_reg,     delta_next;
    logic                  sign_reg,      sign_next;
    logic [PERIOD_W-1:0]   mag_reg,       mag_next;
    logic                  ovalid_reg,    ovalid_next;
    logic                  oacc_reg,      oacc_next;
    logic [COUNT_W-1:0]    oframes_reg,   oframes_next;
    logic [PERIOD_W-1:0]   operiod_reg,   operiod_next;
    logic [PERIOD_W-1:0]   omean_reg,     omean_next;

    div_req_t              div_req;
    div_sts_t              div_sts;
    logic [DIVIDEND_W-1:0] div_q;
    logic [DIVISOR_W-1:0]  div_r;

    logic [COUNT_W-1:0]    in_cnt;
    logic [TIME_W-1:0]     in_time;
    logic [COUNT_W-1:0]    cnt_diff;
    logic                  in_beat;

    assign in_cnt   = s_axis_tdata[COUNT_W-1:0];
    assign in_time  = s_axis_tdata[COUNT_W +: TIME_W];
    assign cnt_diff = in_cnt - prev_cnt_reg;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_axis_tvalid && s_axis_tready;

    vpe_serial_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .sts       (div_sts),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = dt_reg;
        div_req.divisor  = mean_reg;
        unique case (state_reg)
            ST_FR_GO:
            begin
                div_req.start = 1'b1;
            end
            ST_PER_GO:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = DIVISOR_W'(frames_reg);
            end
            ST_MEAN_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVIDEND_W'(mag_reg);
                div_req.divisor  = DIVISOR_W'(total_reg);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        armed_next     = armed_reg;
        prev_cnt_next  = prev_cnt_reg;
        prev_time_next = prev_time_reg;
        total_next     = total_reg;
        mean_next      = mean_reg;
        period_next    = period_reg;
        dt_next        = dt_reg;
        frames_next    = frames_reg;
        acc_next       = acc_reg;
        rnd_next       = rnd_reg;
        delta_next     = delta_reg;
        sign_next      = sign_reg;
        mag_next       = mag_reg;
        ovalid_next    = ovalid_reg && !m_axis_tready;
        oacc_next      = oacc_reg;
        oframes_next   = oframes_reg;
        operiod_next   = operiod_reg;
        omean_next     = omean_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    prev_cnt_next  = in_cnt;
                    prev_time_next = in_time;
                    dt_next        = in_time - prev_time_reg;
                    acc_next       = 1'b0;
                    frames_next    = '0;
                    state_next     = ST_FINISH;
                    if (!armed_reg)
                    begin
                        armed_next = 1'b1;
                    end
                    else if (cnt_diff != '0 && !cnt_diff[COUNT_W-1])
                    begin
                        acc_next = 1'b1;
                        if (mean_reg != '0)
                        begin
                            state_next = ST_FR_GO;
                        end
                        else
                        begin
                            frames_next = cnt_diff;
                            state_next  = ST_PER_GO;
                        end
                    end
                end
            end
            ST_FR_GO:
            begin
                state_next = ST_FR_WAIT;
            end
            ST_FR_WAIT:
            begin
                if (div_sts.done)
                begin
                    rnd_next   = ({div_r, 1'b0} >= {1'b0, mean_reg});
                    state_next = ST_FR_FIX;
                end
            end
            ST_FR_FIX:
            begin
                if (div_q[DIVIDEND_W-1:COUNT_W] != '0 || div_q[COUNT_W-1:0] == COUNT_MAX)
                begin
                    frames_next = COUNT_MAX;
                end
                else if (div_q[COUNT_W-1:0] == '0 && !rnd_reg)
                begin
                    frames_next = COUNT_W'(1);
                end
                else
                begin
                    frames_next = div_q[COUNT_W-1:0] + COUNT_W'(rnd_reg);
                end
                state_next = ST_PER_GO;
            end
            ST_PER_GO:
            begin
                state_next = ST_PER_WAIT;
            end
            ST_PER_WAIT:
            begin
                if (div_sts.done)
                begin
                    if (div_q[DIVIDEND_W-1:PERIOD_W] != '0)
                    begin
                        period_next = PERIOD_MAX;
                    end
                    else
                    begin
                        period_next = div_q[PERIOD_W-1:0];
                    end
                    if (total_reg != COUNT_MAX)
                    begin
                        total_next = total_reg + COUNT_W'(1);
                    end
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA:
            begin
                delta_next = {1'b0, period_reg} - {1'b0, mean_reg};
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                sign_next  = delta_reg[PERIOD_W];
                mag_next   = delta_reg[PERIOD_W] ? PERIOD_W'(-delta_reg)
                                                 : delta_reg[PERIOD_W-1:0];
                state_next = ST_MEAN_GO;
            end
            ST_MEAN_GO:
            begin
                state_next = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (div_sts.done)
                begin
                    mean_next  = sign_reg ? mean_reg - div_q[PERIOD_W-1:0]
                                          : mean_reg + div_q[PERIOD_W-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next  = 1'b1;
                    oacc_next    = acc_reg;
                    oframes_next = frames_reg;
                    operiod_next = period_reg;
                    omean_next   = mean_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            armed_reg     <= 1'b0;
            prev_cnt_reg  <= '0;
            prev_time_reg <= '0;
            total_reg     <= '0;
            mean_reg      <= '0;
            period_reg    <= '0;
            dt_reg        <= '0;
            frames_reg    <= '0;
            acc_reg       <= 1'b0;
            rnd_reg       <= 1'b0;
            delta_reg     <= '0;
            sign_reg      <= 1'b0;
            mag_reg       <= '0;
            ovalid_reg    <= 1'b0;
            oacc_reg      <= 1'b0;
            oframes_reg   <= '0;
            operiod_reg   <= '0;
            omean_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            prev_cnt_reg  <= prev_cnt_next;
            prev_time_reg <= prev_time_next;
            total_reg     <= total_next;
            mean_reg      <= mean_next;
            period_reg    <= period_next;
            dt_reg        <= dt_next;
            frames_reg    <= frames_next;
            acc_reg       <= acc_next;
            rnd_reg       <= rnd_next;
            delta_reg     <= delta_next;
            sign_reg      <= sign_next;
            mag_reg       <= mag_next;
            ovalid_reg    <= ovalid_next;
            oacc_reg      <= oacc_next;
            oframes_reg   <= oframes_next;
            operiod_reg   <= operiod_next;
            omean_reg     <= omean_next;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = oacc_reg;
    assign m_axis_tdata  = {omean_reg, operiod_reg, oframes_reg};

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !div_sts.busy && !div_sts.done)
        else $error("divider active while idle");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> state_reg == ST_FR_WAIT || state_reg == ST_PER_WAIT
                      || state_reg == ST_MEAN_WAIT)
        else $error("divider completion outside a wait state");

    a_acc_frames: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[COUNT_W-1:0] != '0)
        else $error("accepted beat with zero frame count");

    a_skip_frames: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[COUNT_W-1:0] == '0)
        else $error("skipped beat with nonzero frame count");

    a_first_arms: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && !armed_reg |=> armed_reg && state_reg == ST_FINISH)
        else $error("first event did not arm the tracker");

endmodule

### hdl/vpe_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpe_serial_div
// Restoring divider, one quotient bit per cycle through a dividend shift
// register. Quotient and remainder hold after done until the next start.
// ----------------------------------------------------------------------------
module vpe_serial_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  vpe_pkg::div_req_t                   req,
    output vpe_pkg::div_sts_t                   sts,
    output logic [vpe_pkg::DIVIDEND_W-1:0]      quotient,
    output logic [vpe_pkg::DIVISOR_W-1:0]       remainder
);
    import vpe_pkg::*;

    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVIDEND_W-1:0] quot_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIVISOR_W-1:0]  dsr_next;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIV_CNT_W-1:0]  cnt_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    assign trial = {rem_reg, quot_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DIVISOR_W])
            begin
                rem_next  = diff[DIVISOR_W-1:0];
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DIVISOR_W-1:0];
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule
